/* hw/rtl/lrm_pkg.sv */
// ----------------------------------------------------------------------------
// lrm_pkg
// Shared types for the midpoint line rasteriser: item kinds and the
// command word that passes from the front end to the stepper.
// ----------------------------------------------------------------------------
package lrm_pkg;

    typedef enum logic
    {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t kind;
        logic  steep;
        logic  minor_down;
        logic  nonzero;
    } cmd_t;

    localparam int CMD_BITS = $bits(cmd_t);

endpackage

/* hw/rtl/line_raster_midpoint.sv */
// Path: an item accepted at the input is written into the queue; the stepper pops it and
// registers the pixel of a step for an active line in the output slot.
// Throughput: one item per cycle; the stepper retires one queue entry per clock, save that
// a step for an active line waits while the output slot is held. The queue (two entries)
// stalls the input only when the output side holds off. Reset (rst_n low, asynchronous)
// empties the queue, clears the output slot and leaves no line active.
// ----------------------------------------------------------------------------
// line_raster_midpoint
// Integer midpoint line rasteriser: a front end decodes loads, a short
// queue decouples it from the stepper, which emits one pixel per step of an active line.
// ----------------------------------------------------------------------------
module line_raster_midpoint
    import lrm_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last
);

    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int ENTRY_BITS = CMD_BITS + 5 * COORD_BITS + ERR_BITS;

    cmd_t                  f_cmd;
    logic [COORD_BITS-1:0] f_major_pos;
    logic [COORD_BITS-1:0] f_minor_pos;
    logic [COORD_BITS-1:0] f_major_stop;
    logic [COORD_BITS-1:0] f_delta_major;
    logic [COORD_BITS-1:0] f_delta_minor;
    logic [ERR_BITS-1:0]   f_error;

    cmd_t                  b_cmd;
    logic [COORD_BITS-1:0] b_major_pos;
    logic [COORD_BITS-1:0] b_minor_pos;
    logic [COORD_BITS-1:0] b_major_stop;
    logic [COORD_BITS-1:0] b_delta_major;
    logic [COORD_BITS-1:0] b_delta_minor;
    logic [ERR_BITS-1:0]   b_error;

    logic [ENTRY_BITS-1:0] push_data;
    logic [ENTRY_BITS-1:0] pop_data;
    logic                  q_full;
    logic                  q_nonempty;
    logic                  q_pop;

    lrm_front #(
        .COORD_BITS (COORD_BITS),
        .ERR_BITS   (ERR_BITS)
    ) u_front (
        .kind        (kind),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .cmd         (f_cmd),
        .major_pos   (f_major_pos),
        .minor_pos   (f_minor_pos),
        .major_stop  (f_major_stop),
        .delta_major (f_delta_major),
        .delta_minor (f_delta_minor),
        .error_init  (f_error)
    );

    assign push_data = {f_cmd, f_major_pos, f_minor_pos, f_major_stop,
                        f_delta_major, f_delta_minor, f_error};

    lrm_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .nonempty  (q_nonempty)
    );

    assign in_stall = q_full;

    assign {b_cmd, b_major_pos, b_minor_pos, b_major_stop,
            b_delta_major, b_delta_minor, b_error} = pop_data;

    lrm_back #(
        .COORD_BITS (COORD_BITS),
        .ERR_BITS   (ERR_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (q_nonempty),
        .cmd_pop          (q_pop),
        .cmd              (b_cmd),
        .load_major_pos   (b_major_pos),
        .load_minor_pos   (b_minor_pos),
        .load_major_stop  (b_major_stop),
        .load_delta_major (b_delta_major),
        .load_delta_minor (b_delta_minor),
        .load_error       (b_error),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pixel_x          (pixel_x),
        .pixel_y          (pixel_y),
        .last             (last)
    );

endmodule

/* hw/rtl/lrm_front.sv */
// ----------------------------------------------------------------------------
// lrm_front
// Classifies an incoming item and, for a load, works out the major axis,
// start point, stop coordinate, deltas and initial decision term.
// ----------------------------------------------------------------------------
module lrm_front
    import lrm_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int ERR_BITS   = COORD_BITS + 3
)
(
    input  logic                  kind,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output cmd_t                  cmd,
    output logic [COORD_BITS-1:0] major_pos,
    output logic [COORD_BITS-1:0] minor_pos,
    output logic [COORD_BITS-1:0] major_stop,
    output logic [COORD_BITS-1:0] delta_major,
    output logic [COORD_BITS-1:0] delta_minor,
    output logic [ERR_BITS-1:0]   error_init
);

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   dx_neg;
    logic [COORD_BITS:0]   dy_neg;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  steep;
    logic                  same_sign;
    logic [COORD_BITS-1:0] a_maj;
    logic [COORD_BITS-1:0] a_min;
    logic [COORD_BITS-1:0] b_maj;
    logic [COORD_BITS-1:0] b_min;

    assign dx     = {1'b0, end_x} - {1'b0, start_x};
    assign dy     = {1'b0, end_y} - {1'b0, start_y};
    assign dx_neg = ~dx + 1'b1;
    assign dy_neg = ~dy + 1'b1;
    assign adx    = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign ady    = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

    assign steep     = ady > adx;
    assign same_sign = (dx != '0) && (dy != '0) && (dx[COORD_BITS] == dy[COORD_BITS]);

    always_comb
    begin
        if (steep)
        begin
            a_maj       = start_y;
            a_min       = start_x;
            b_maj       = end_y;
            b_min       = end_x;
            delta_major = ady;
            delta_minor = adx;
        end
        else
        begin
            a_maj       = start_x;
            a_min       = start_y;
            b_maj       = end_x;
            b_min       = end_y;
            delta_major = adx;
            delta_minor = ady;
        end
    end

    always_comb
    begin
        if (a_maj <= b_maj)
        begin
            major_pos  = a_maj;
            minor_pos  = a_min;
            major_stop = b_maj;
        end
        else
        begin
            major_pos  = b_maj;
            minor_pos  = b_min;
            major_stop = a_maj;
        end
    end

    assign error_init = {3'b000, delta_major} - {2'b00, delta_minor, 1'b0};

    assign cmd.kind       = kind_t'(kind);
    assign cmd.steep      = steep;
    assign cmd.minor_down = !same_sign;
    assign cmd.nonzero    = delta_major != '0;

endmodule

/* hw/rtl/lrm_queue.sv */
// ----------------------------------------------------------------------------
// lrm_queue
// Short first-in first-out queue of decoded commands between the front end
// and the stepper. Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module lrm_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             nonempty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full     = count_reg == CNT_BITS'(DEPTH);
    assign nonempty = count_reg != '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/lrm_back.sv */
// ----------------------------------------------------------------------------
// lrm_back
// Line stepper: holds the active line, takes one queue command per cycle
// unless stalled and emits one pixel per step into a registered output slot.
// ----------------------------------------------------------------------------
module lrm_back
    import lrm_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int ERR_BITS   = COORD_BITS + 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_pop,
    input  cmd_t                  cmd,
    input  logic [COORD_BITS-1:0] load_major_pos,
    input  logic [COORD_BITS-1:0] load_minor_pos,
    input  logic [COORD_BITS-1:0] load_major_stop,
    input  logic [COORD_BITS-1:0] load_delta_major,
    input  logic [COORD_BITS-1:0] load_delta_minor,
    input  logic [ERR_BITS-1:0]   load_error,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last
);

    logic                  active_reg;
    logic                  active_next;
    logic                  steep_reg;
    logic                  steep_next;
    logic                  down_reg;
    logic                  down_next;
    logic [COORD_BITS-1:0] major_reg;
    logic [COORD_BITS-1:0] major_next;
    logic [COORD_BITS-1:0] minor_reg;
    logic [COORD_BITS-1:0] minor_next;
    logic [COORD_BITS-1:0] stop_reg;
    logic [COORD_BITS-1:0] stop_next;
    logic [COORD_BITS-1:0] dmaj_reg;
    logic [COORD_BITS-1:0] dmaj_next;
    logic [COORD_BITS-1:0] dmin_reg;
    logic [COORD_BITS-1:0] dmin_next;
    logic [ERR_BITS-1:0]   err_reg;
    logic [ERR_BITS-1:0]   err_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg;
    logic [COORD_BITS-1:0] pixel_x_next;
    logic [COORD_BITS-1:0] pixel_y_reg;
    logic [COORD_BITS-1:0] pixel_y_next;
    logic                  last_reg;
    logic                  last_next;

    logic                  slot_free;
    logic                  is_load;
    logic                  do_load;
    logic                  do_emit;
    logic [COORD_BITS-1:0] major_inc;
    logic                  at_end;
    logic [ERR_BITS-1:0]   dmin_x2;
    logic [ERR_BITS-1:0]   dmaj_x2;

    assign slot_free = !out_valid_reg || !out_stall;
    assign is_load   = cmd.kind == KIND_LOAD;
    assign cmd_pop   = cmd_valid && (is_load || !active_reg || slot_free);
    assign do_load   = cmd_pop && is_load;
    assign do_emit   = cmd_pop && !is_load && active_reg;

    assign major_inc = major_reg + 1'b1;
    assign at_end    = major_inc == stop_reg;
    assign dmin_x2   = {2'b00, dmin_reg, 1'b0};
    assign dmaj_x2   = {2'b00, dmaj_reg, 1'b0};

    always_comb
    begin
        active_next = active_reg;
        steep_next  = steep_reg;
        down_next   = down_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        stop_next   = stop_reg;
        dmaj_next   = dmaj_reg;
        dmin_next   = dmin_reg;
        err_next    = err_reg;
        if (do_load)
        begin
            active_next = cmd.nonzero;
            steep_next  = cmd.steep;
            down_next   = cmd.minor_down;
            major_next  = load_major_pos;
            minor_next  = load_minor_pos;
            stop_next   = load_major_stop;
            dmaj_next   = load_delta_major;
            dmin_next   = load_delta_minor;
            err_next    = load_error;
        end
        else if (do_emit)
        begin
            if (!err_reg[ERR_BITS-1])
            begin
                err_next = err_reg - dmin_x2;
            end
            else
            begin
                err_next   = err_reg + dmaj_x2 - dmin_x2;
                minor_next = down_reg ? minor_reg - 1'b1 : minor_reg + 1'b1;
            end
            major_next = major_inc;
            if (at_end)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pixel_x_next   = pixel_x_reg;
        pixel_y_next   = pixel_y_reg;
        last_next      = last_reg;
        if (do_emit)
        begin
            out_valid_next = 1'b1;
            pixel_x_next   = steep_reg ? minor_reg : major_reg;
            pixel_y_next   = steep_reg ? major_reg : minor_reg;
            last_next      = at_end;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            steep_reg     <= 1'b0;
            down_reg      <= 1'b0;
            major_reg     <= '0;
            minor_reg     <= '0;
            stop_reg      <= '0;
            dmaj_reg      <= '0;
            dmin_reg      <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            steep_reg     <= steep_next;
            down_reg      <= down_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            stop_reg      <= stop_next;
            dmaj_reg      <= dmaj_next;
            dmin_reg      <= dmin_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg <= pixel_x_next;
        pixel_y_reg <= pixel_y_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign last      = last_reg;

endmodule

/* test/line_raster_midpoint_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_raster_midpoint_tb
// Checks the midpoint line rasteriser against a predictor of its own. Loads
// and steps are sent through the valid/stall input channel. Every pixel
// transfer is compared, field by field, with the oldest pixel predicted.
// Directed cases come first: steps with no line, zero-length lines, the
// decision tie, coordinate extremes, steep lines and reloads. A long output
// hold then fills the block and stalls its input. The run ends with random
// strokes, most of them stepped to their end, and random idling on both
// channels that stops near the finish.
// ----------------------------------------------------------------------------
module line_raster_midpoint_tb;
    import lrm_pkg::*;

    localparam int CB          = 12;
    localparam int CMAX        = (1 << CB) - 1;
    localparam int ITEM_TARGET = 1900;
    localparam int CALM_TARGET = 1650;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed
    {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          last;
    } pixel_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic          kind = KIND_LOAD;
    logic [CB-1:0] start_x = '0;
    logic [CB-1:0] start_y = '0;
    logic [CB-1:0] end_x = '0;
    logic [CB-1:0] end_y = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [CB-1:0] pixel_x;
    logic [CB-1:0] pixel_y;
    logic          last;

    pixel_t        pending_pixels[$];
    int            error_count = 0;
    int            items_sent = 0;
    bit            idle_enable = 1'b1;
    bit            long_hold_req = 1'b0;
    int            hold_left = 0;
    int            stall_left = 0;

    // Predictor state
    bit            line_on = 1'b0;
    bit            steep_line = 1'b0;
    bit            minor_dec = 1'b0;
    logic [CB-1:0] maj_pos = '0;
    logic [CB-1:0] maj_stop = '0;
    logic [CB-1:0] min_pos = '0;
    logic [CB-1:0] d_maj = '0;
    logic [CB-1:0] d_min = '0;
    int            decision = 0;

    line_raster_midpoint #(.COORD_BITS(CB)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (last)
    );

    always #6 clk = ~clk;

    function automatic void predict_pixel(input kind_t k, input logic [CB-1:0] sx,
                                          input logic [CB-1:0] sy, input logic [CB-1:0] ex,
                                          input logic [CB-1:0] ey);
        int     dx;
        int     dy;
        int     adx;
        int     ady;
        pixel_t px;
        if (k == KIND_LOAD)
        begin
            dx = int'(ex) - int'(sx);
            dy = int'(ey) - int'(sy);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            steep_line = ady > adx;
            minor_dec = !((dx > 0 && dy > 0) || (dx < 0 && dy < 0));
            if (steep_line)
            begin
                d_maj = ady[CB-1:0];
                d_min = adx[CB-1:0];
                if (sy <= ey)
                begin
                    maj_pos = sy; min_pos = sx; maj_stop = ey;
                end
                else
                begin
                    maj_pos = ey; min_pos = ex; maj_stop = sy;
                end
            end
            else
            begin
                d_maj = adx[CB-1:0];
                d_min = ady[CB-1:0];
                if (sx <= ex)
                begin
                    maj_pos = sx; min_pos = sy; maj_stop = ex;
                end
                else
                begin
                    maj_pos = ex; min_pos = ey; maj_stop = sx;
                end
            end
            decision = int'(d_maj) - 2 * int'(d_min);
            line_on = d_maj != 0;
        end
        else if (line_on)
        begin
            px.x = steep_line ? min_pos : maj_pos;
            px.y = steep_line ? maj_pos : min_pos;
            px.last = (maj_pos + 1'b1) == maj_stop;
            pending_pixels.push_back(px);
            if (decision >= 0)
                decision -= 2 * int'(d_min);
            else
            begin
                decision += 2 * (int'(d_maj) - int'(d_min));
                min_pos = minor_dec ? min_pos - 1'b1 : min_pos + 1'b1;
            end
            maj_pos = maj_pos + 1'b1;
            if (px.last)
                line_on = 1'b0;
        end
    endfunction

    task automatic send_item(input kind_t k, input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                             input logic [CB-1:0] ex, input logic [CB-1:0] ey);
        bit taken;
        int gap;
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        predict_pixel(k, sx, sy, ex, ey);
        items_sent++;
    endtask

    task automatic send_step();
        send_item(KIND_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
    endtask

    task automatic send_load(input int sx, input int sy, input int ex, input int ey);
        send_item(KIND_LOAD, CB'(sx), CB'(sy), CB'(ex), CB'(ey));
    endtask

    task automatic test_no_line();
        send_step();
        send_load(5, 5, 5, 5);
        send_step();
    endtask

    task automatic test_tie_at_top_corner();
        // Shallow line, same sign, decision starts at zero; one step past the end
        send_load(CMAX, CMAX, CMAX - 4, CMAX - 2);
        repeat (5) send_step();
    endtask

    task automatic test_steep_and_reload();
        send_load(0, CMAX, 2, CMAX - 5);
        repeat (2) send_step();
        send_load(10, 10, 12, 13);
        send_step();
        send_load(0, 0, 3, 0);
        repeat (3) send_step();
        send_load(CMAX, 0, 0, 1);
        repeat (2) send_step();
    endtask

    task automatic test_long_hold();
        in_valid <= 1'b0;
        @(negedge clk);
        long_hold_req = 1'b1;
        @(posedge clk);
        send_load(100, 200, 140, 185);
        repeat (40) send_step();
    endtask

    task automatic pick_endpoint(input int origin, input int reach, output int far_end);
        int offset;
        offset = $urandom_range(0, reach);
        far_end = $urandom_range(0, 1) ? origin + offset : origin - offset;
        if (far_end > CMAX || far_end < 0)
            far_end = 2 * origin - far_end;
    endtask

    task automatic test_random_strokes(input int target);
        int sx;
        int sy;
        int ex;
        int ey;
        int reach;
        int span;
        int choice;
        while (items_sent < target)
        begin
            choice = $urandom_range(0, 9);
            sx = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? CMAX : 0)
                                             : $urandom_range(0, CMAX);
            sy = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? CMAX : 0)
                                             : $urandom_range(0, CMAX);
            if (choice < 7)
            begin
                reach = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200)
                                                     : $urandom_range(1, 24);
                pick_endpoint(sx, reach, ex);
                pick_endpoint(sy, reach, ey);
                span = (ex > sx) ? ex - sx : sx - ex;
                if (((ey > sy) ? ey - sy : sy - ey) > span)
                    span = (ey > sy) ? ey - sy : sy - ey;
                send_load(sx, sy, ex, ey);
                if ($urandom_range(0, 4) == 0)
                    span = $urandom_range(0, span);
                else
                    span = span + $urandom_range(0, 2);
                repeat (span) send_step();
            end
            else if (choice == 7)
            begin
                send_load(sx, sy, sx, sy);
                repeat ($urandom_range(0, 2)) send_step();
            end
            else
            begin
                send_load($urandom_range(0, CMAX), $urandom_range(0, CMAX),
                          $urandom_range(0, CMAX), $urandom_range(0, CMAX));
                repeat ($urandom_range(0, 6)) send_step();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (!idle_enable)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 8);
            end
        end
    end

    always @(negedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel transfer x=%0d y=%0d last=%0b", pixel_x, pixel_y, last);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_x !== want.x)
                begin
                    $error("pixel_x: expected %0d, actual %0d", want.x, pixel_x);
                    error_count++;
                end
                if (pixel_y !== want.y)
                begin
                    $error("pixel_y: expected %0d, actual %0d", want.y, pixel_y);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_line();
        test_tie_at_top_corner();
        test_steep_and_reload();
        test_long_hold();
        test_random_strokes(CALM_TARGET);
        idle_enable = 1'b0;
        test_random_strokes(ITEM_TARGET);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lrm_pkg.sv
hw/rtl/lrm_front.sv
hw/rtl/lrm_queue.sv
hw/rtl/lrm_back.sv
hw/rtl/line_raster_midpoint.sv
test/line_raster_midpoint_tb.sv
